// ===== src/cfr_pkg.sv =====
// Shared types and constants of the command frame responder.
package cfr_pkg;

    // Input operation codes carried in s_tuser.
    localparam logic [1:0] OP_REQ    = 2'd0;
    localparam logic [1:0] OP_CAP    = 2'd1;
    localparam logic [1:0] OP_TXDONE = 2'd2;
    localparam logic [1:0] OP_IGNORE = 2'd3;

    // Result kinds.
    localparam logic [1:0] KIND_STATUS = 2'd0;
    localparam logic [1:0] KIND_REPLY  = 2'd1;
    localparam logic [1:0] KIND_FRAME  = 2'd2;

    // Status codes.
    localparam logic [1:0] ST_NONE     = 2'd0;
    localparam logic [1:0] ST_ACCEPTED = 2'd1;
    localparam logic [1:0] ST_MISMATCH = 2'd2;

    // Request commands (bits 6..0 of request byte 1) and the read flag.
    localparam logic [6:0] CMD_RATE   = 7'h01;
    localparam logic [6:0] CMD_LEN    = 7'h02;
    localparam logic [6:0] CMD_FRAMES = 7'h04;
    localparam logic [6:0] CMD_DEPTH  = 7'h06;
    localparam int         RD_BIT     = 7;

    // Smallest request that is processed, and reply lengths.
    localparam int MIN_REQUEST   = 5;
    localparam int LEN_RATE_WR   = 5;
    localparam int LEN_LEN_RD    = 6;
    localparam int LEN_LONG_RD   = 7;
    localparam logic [7:0] TAG_RATE = 8'h02;
    localparam logic [7:0] TAG_LEN  = 8'h01;

    localparam logic [6:0] FRAME_LEN_RESET = 7'd8;

    typedef enum logic [3:0] {
        S_IDLE,
        S_REQ_EVAL,
        S_CAP_CHECK,
        S_COPY,
        S_DRAIN_CHECK,
        S_DRAIN_RD,
        S_DRAIN_OUT,
        S_REPLY_RD,
        S_REPLY_OUT,
        S_STAT_OUT
    } cfr_state_t;

    typedef enum logic [1:0] {
        MODE_REPLY,
        MODE_FRAME,
        MODE_STATUS
    } cfr_mode_t;

    typedef struct packed {
        logic      in_ready;
        logic      accept;
        logic      req_eval;
        logic      cap_drop;
        logic      copy_start;
        logic      copy_step;
        logic      copy_finish;
        logic      drain_start;
        logic      drain_adv;
        logic      reply_adv;
        logic      out_valid;
        cfr_mode_t out_mode;
    } cfr_cmd_t;

    typedef struct packed {
        logic busy;
        logic req_discard;
        logic req_reply;
        logic req_bad;
        logic cap_complete;
        logic fifo_full;
        logic copy_done;
        logic can_drain;
        logic drop;
        logic drain_last;
        logic reply_last;
    } cfr_status_t;

endpackage

// ===== src/cfr_ctrl.sv =====
// Controller state machine of the command frame responder.
module cfr_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic [1:0]           s_tuser,
    input  logic                 s_tlast,
    input  logic                 m_tready,
    input  cfr_pkg::cfr_status_t st,
    output cfr_pkg::cfr_cmd_t    cmd
);
    import cfr_pkg::*;

    cfr_state_t state_reg, state_next;
    logic       ready;
    logic       take;

    assign ready = (state_reg == S_IDLE) && !st.busy;
    assign take  = ready && s_tvalid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (take) begin
                    if (s_tuser == OP_REQ && s_tlast) begin
                        state_next = S_REQ_EVAL;
                    end else if (s_tuser == OP_CAP && st.cap_complete) begin
                        state_next = S_CAP_CHECK;
                    end else if (s_tuser == OP_TXDONE) begin
                        state_next = S_DRAIN_CHECK;
                    end
                end
            end
            S_REQ_EVAL: begin
                priority if (st.req_discard) begin
                    state_next = S_IDLE;
                end else if (st.req_reply) begin
                    state_next = S_REPLY_RD;
                end else if (st.req_bad) begin
                    state_next = S_STAT_OUT;
                end else begin
                    state_next = S_IDLE;
                end
            end
            S_CAP_CHECK: begin
                state_next = st.fifo_full ? S_DRAIN_CHECK : S_COPY;
            end
            S_COPY: begin
                if (st.copy_done) begin
                    state_next = S_DRAIN_CHECK;
                end
            end
            S_DRAIN_CHECK: begin
                priority if (st.can_drain) begin
                    state_next = S_DRAIN_RD;
                end else if (st.drop) begin
                    state_next = S_STAT_OUT;
                end else begin
                    state_next = S_IDLE;
                end
            end
            S_DRAIN_RD: state_next = S_DRAIN_OUT;
            S_DRAIN_OUT: begin
                if (m_tready) begin
                    state_next = st.drain_last ? S_IDLE : S_DRAIN_RD;
                end
            end
            S_REPLY_RD: state_next = S_REPLY_OUT;
            S_REPLY_OUT: begin
                if (m_tready) begin
                    state_next = st.reply_last ? S_IDLE : S_REPLY_RD;
                end
            end
            S_STAT_OUT: begin
                if (m_tready) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        cmd             = '0;
        cmd.out_mode    = MODE_STATUS;
        cmd.in_ready    = ready;
        cmd.accept      = take;
        cmd.req_eval    = (state_reg == S_REQ_EVAL);
        cmd.cap_drop    = (state_reg == S_CAP_CHECK) && st.fifo_full;
        cmd.copy_start  = (state_reg == S_CAP_CHECK) && !st.fifo_full;
        cmd.copy_step   = (state_reg == S_COPY);
        cmd.copy_finish = (state_reg == S_COPY) && st.copy_done;
        cmd.drain_start = (state_reg == S_DRAIN_CHECK) && st.can_drain;
        cmd.drain_adv   = (state_reg == S_DRAIN_OUT) && m_tready && !st.drain_last;
        cmd.reply_adv   = (state_reg == S_REPLY_OUT) && m_tready;
        unique case (state_reg)
            S_DRAIN_OUT: begin
                cmd.out_valid = 1'b1;
                cmd.out_mode  = MODE_FRAME;
            end
            S_REPLY_OUT: begin
                cmd.out_valid = 1'b1;
                cmd.out_mode  = MODE_REPLY;
            end
            S_STAT_OUT: begin
                cmd.out_valid = 1'b1;
                cmd.out_mode  = MODE_STATUS;
            end
            default: begin
                cmd.out_valid = 1'b0;
            end
        endcase
    end

endmodule

// ===== src/cfr_datapath.sv =====
// Datapath: request store, capture line buffer, frame FIFO, depth divider and result mux.
module cfr_datapath #(
    parameter int BUFFER_BYTES = 1024,
    parameter int MAX_FRAME    = 64,
    parameter int MAX_REQUEST  = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wen,
    input  logic [6:0]           cfg_wdata,
    input  logic [7:0]           s_tdata,
    input  logic [1:0]           s_tuser,
    input  logic                 s_tlast,
    input  cfr_pkg::cfr_cmd_t    cmd,
    output cfr_pkg::cfr_status_t st,
    output logic [7:0]           m_tdata,
    output logic [4:0]           m_tuser,
    output logic                 m_tlast
);
    import cfr_pkg::*;

    localparam int LMAX_A = (MAX_FRAME < BUFFER_BYTES) ? MAX_FRAME : BUFFER_BYTES;
    localparam int LMAX   = (LMAX_A < 127) ? LMAX_A : 127;
    localparam int LB_AW  = (LMAX > 1) ? $clog2(LMAX) : 1;
    localparam int Q_W    = $clog2(BUFFER_BYTES + 1);
    localparam int DC_W   = $clog2(Q_W + 1);
    localparam int AW     = $clog2(BUFFER_BYTES);
    localparam int RQ_AW  = $clog2(MAX_REQUEST);
    localparam int RC_W   = $clog2(MAX_REQUEST + 2);

    // Configuration and effective frame length.
    logic [6:0] frame_len_reg;
    logic [6:0] len_w;

    // Depth divider: BUFFER_BYTES / len, one quotient bit per cycle.
    logic [DC_W-1:0] div_cnt_reg;
    logic [Q_W-1:0]  div_dvd_reg;
    logic [Q_W-1:0]  div_q_reg;
    logic [7:0]      div_rem_reg;
    logic [7:0]      div_t;

    // Request side.
    logic [7:0]       rq_mem [MAX_REQUEST];
    logic [7:0]       rq_rd_reg;
    logic [RC_W-1:0]  count_reg;
    logic [15:0]      sum_reg;
    logic [7:0]       b1_reg, b3_reg, b4_reg, last_reg, prev_reg;
    logic [15:0]      rate_reg;
    logic [7:0]       fts_reg;
    logic [15:0]      chk;
    logic             bad;
    logic             discard;

    // Decoded command, registered for the reply.
    logic [RC_W-1:0]  ev_len;
    logic             ev_reply, ev_acc, ev_o2, ev_o3, ev_o4, ev_rate_we, ev_fts_we;
    logic [7:0]       ev_v2, ev_v3, ev_v4;
    logic [15:0]      depth16;
    logic [RC_W-1:0]  rlen_reg, idx_reg;
    logic             acc_reg, bad_reg, o2_reg, o3_reg, o4_reg;
    logic [7:0]       v2_reg, v3_reg, v4_reg;
    logic [15:0]      rsum_reg;
    logic [7:0]       reply_byte;

    // Capture and frame FIFO.
    logic [7:0]       lb_mem [LMAX];
    logic [LMAX-1:0]  lb_vld_reg;
    logic [7:0]       lb_rd_reg;
    logic             lb_vld_rd_reg;
    logic [6:0]       cap_idx_reg;
    logic [6:0]       j_reg;
    logic [7:0]       fr_mem [BUFFER_BYTES];
    logic [7:0]       fr_rd_reg;
    logic [AW-1:0]    head_reg, tail_reg, rd_base_reg;
    logic [Q_W-1:0]   fill_reg;
    logic             drop_reg;
    logic [AW-1:0]    head_next, tail_next;
    logic             cap_take, req_take;

    function automatic logic [AW-1:0] slot_next(input logic [AW-1:0] base,
                                                 input logic [6:0] len);
        logic [AW+1:0] nxt;
        nxt = (AW+2)'(base) + (AW+2)'(len);
        // The next slot must still hold a whole frame, else wrap.
        if (nxt + (AW+2)'(len) > (AW+2)'(BUFFER_BYTES)) begin
            return '0;
        end
        return nxt[AW-1:0];
    endfunction

    always_comb begin
        if (frame_len_reg == 7'd0) begin
            len_w = 7'd1;
        end else if (frame_len_reg > 7'(LMAX)) begin
            len_w = 7'(LMAX);
        end else begin
            len_w = frame_len_reg;
        end
    end

    assign div_t    = {div_rem_reg[6:0], div_dvd_reg[Q_W-1]};
    assign depth16  = 16'(div_q_reg);
    assign cap_take = cmd.accept && (s_tuser == OP_CAP);
    assign req_take = cmd.accept && (s_tuser == OP_REQ);
    assign head_next = slot_next(head_reg, len_w);
    assign tail_next = slot_next(tail_reg, len_w);

    // The last two stored bytes are the received sum, low byte first.
    assign chk     = sum_reg - 16'(last_reg) - 16'(prev_reg);
    assign bad     = (chk != {last_reg, prev_reg});
    assign discard = (count_reg > RC_W'(MAX_REQUEST)) || (count_reg < RC_W'(MIN_REQUEST))
                     || (fts_reg != 8'd0);

    always_comb begin
        ev_len     = count_reg;
        ev_reply   = 1'b1;
        ev_acc     = 1'b0;
        ev_o2      = 1'b0;
        ev_o3      = 1'b0;
        ev_o4      = 1'b0;
        ev_v2      = 8'd0;
        ev_v3      = 8'd0;
        ev_v4      = 8'd0;
        ev_rate_we = 1'b0;
        ev_fts_we  = 1'b0;
        unique case (b1_reg[6:0])
            CMD_RATE: begin
                ev_acc = 1'b1;
                ev_o2  = 1'b1;
                if (b1_reg[RD_BIT]) begin
                    ev_len = RC_W'(LEN_LONG_RD);
                    ev_v2  = TAG_RATE;
                    ev_o3  = 1'b1;
                    ev_o4  = 1'b1;
                    ev_v3  = rate_reg[15:8];
                    ev_v4  = rate_reg[7:0];
                end else begin
                    ev_len     = RC_W'(LEN_RATE_WR);
                    ev_rate_we = 1'b1;
                end
            end
            CMD_LEN: begin
                ev_acc = 1'b1;
                if (b1_reg[RD_BIT]) begin
                    ev_len = RC_W'(LEN_LEN_RD);
                    ev_o2  = 1'b1;
                    ev_o3  = 1'b1;
                    ev_v2  = TAG_LEN;
                    ev_v3  = {1'b0, len_w};
                end
            end
            CMD_FRAMES: begin
                if (!b1_reg[RD_BIT]) begin
                    ev_reply  = 1'b0;
                    ev_fts_we = 1'b1;
                end
            end
            CMD_DEPTH: begin
                if (b1_reg[RD_BIT]) begin
                    ev_len = RC_W'(LEN_LONG_RD);
                    ev_o3  = 1'b1;
                    ev_o4  = 1'b1;
                    ev_v3  = depth16[15:8];
                    ev_v4  = depth16[7:0];
                end
            end
            default: ev_reply = 1'b0;
        endcase
    end

    always_comb begin
        if (idx_reg == rlen_reg - RC_W'(2)) begin
            reply_byte = rsum_reg[15:8];
        end else if (idx_reg == rlen_reg - RC_W'(1)) begin
            reply_byte = rsum_reg[7:0];
        end else if (o2_reg && idx_reg == RC_W'(2)) begin
            reply_byte = v2_reg;
        end else if (o3_reg && idx_reg == RC_W'(3)) begin
            reply_byte = v3_reg;
        end else if (o4_reg && idx_reg == RC_W'(4)) begin
            reply_byte = v4_reg;
        end else begin
            reply_byte = rq_rd_reg;
        end
    end

    always_comb begin
        st              = '0;
        st.busy         = (div_cnt_reg != '0);
        st.req_discard  = discard;
        st.req_reply    = ev_reply;
        st.req_bad      = bad;
        st.cap_complete = s_tlast || ((cap_idx_reg + 7'd1) == len_w);
        st.fifo_full    = (fill_reg >= div_q_reg);
        st.copy_done    = (j_reg == len_w);
        st.can_drain    = (fill_reg != '0) && (fts_reg != 8'd0);
        st.drop         = drop_reg;
        st.drain_last   = (j_reg == len_w - 7'd1);
        st.reply_last   = (idx_reg == rlen_reg - RC_W'(1));
    end

    // m_tuser: [1:0] item_kind, [3:2] status_code, [4] dropped_frame.
    always_comb begin
        unique case (cmd.out_mode)
            MODE_REPLY: begin
                m_tdata = reply_byte;
                m_tlast = st.reply_last;
                m_tuser = {1'b0,
                           (idx_reg == '0 && bad_reg) ? ST_MISMATCH
                               : (acc_reg ? ST_ACCEPTED : ST_NONE),
                           KIND_REPLY};
            end
            MODE_FRAME: begin
                m_tdata = fr_rd_reg;
                m_tlast = st.drain_last;
                m_tuser = {(j_reg == 7'd0) && drop_reg, ST_NONE, KIND_FRAME};
            end
            default: begin
                m_tdata = 8'd0;
                m_tlast = 1'b1;
                m_tuser = {drop_reg, drop_reg ? ST_NONE : ST_MISMATCH, KIND_STATUS};
            end
        endcase
    end

    // Memories.
    always_ff @(posedge aclk) begin
        if (req_take && count_reg < RC_W'(MAX_REQUEST)) begin
            rq_mem[count_reg[RQ_AW-1:0]] <= s_tdata;
        end
        rq_rd_reg <= rq_mem[idx_reg[RQ_AW-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (cap_take) begin
            lb_mem[cap_idx_reg[LB_AW-1:0]] <= s_tdata;
        end
        lb_rd_reg     <= lb_mem[j_reg[LB_AW-1:0]];
        lb_vld_rd_reg <= lb_vld_reg[j_reg[LB_AW-1:0]];
    end

    always_ff @(posedge aclk) begin
        // The copy lags the registered line buffer read by one entry: it writes byte j-1 while byte j is read.
        if (cmd.copy_step && j_reg != 7'd0) begin
            fr_mem[tail_reg + AW'(j_reg - 7'd1)] <= lb_vld_rd_reg ? lb_rd_reg : 8'd0;
        end
        fr_rd_reg <= fr_mem[rd_base_reg + AW'(j_reg)];
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (req_take && count_reg < RC_W'(MAX_REQUEST)) begin
            last_reg <= s_tdata;
            prev_reg <= last_reg;
            if (count_reg == RC_W'(1)) b1_reg <= s_tdata;
            if (count_reg == RC_W'(3)) b3_reg <= s_tdata;
            if (count_reg == RC_W'(4)) b4_reg <= s_tdata;
        end
        if (cmd.req_eval) begin
            rlen_reg <= ev_len;
            acc_reg  <= ev_acc;
            bad_reg  <= bad;
            o2_reg   <= ev_o2;
            o3_reg   <= ev_o3;
            o4_reg   <= ev_o4;
            v2_reg   <= ev_v2;
            v3_reg   <= ev_v3;
            v4_reg   <= ev_v4;
            idx_reg  <= '0;
            rsum_reg <= 16'd0;
        end else if (cmd.reply_adv) begin
            if (idx_reg < rlen_reg - RC_W'(2)) begin
                rsum_reg <= rsum_reg + 16'(reply_byte);
            end
            idx_reg <= idx_reg + RC_W'(1);
        end
        if (cmd.drain_start) begin
            rd_base_reg <= head_reg;
        end
        if (cmd.copy_start || cmd.drain_start) begin
            j_reg <= 7'd0;
        end else if (cmd.copy_step || cmd.drain_adv) begin
            j_reg <= j_reg + 7'd1;
        end
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_len_reg <= FRAME_LEN_RESET;
            div_cnt_reg   <= DC_W'(Q_W);
            div_dvd_reg   <= Q_W'(BUFFER_BYTES);
            div_q_reg     <= '0;
            div_rem_reg   <= 8'd0;
            count_reg     <= '0;
            sum_reg       <= 16'd0;
            rate_reg      <= 16'd0;
            fts_reg       <= 8'd0;
            head_reg      <= '0;
            tail_reg      <= '0;
            fill_reg      <= '0;
            cap_idx_reg   <= 7'd0;
            lb_vld_reg    <= '0;
            drop_reg      <= 1'b0;
        end else begin
            if (cfg_wen) begin
                frame_len_reg <= cfg_wdata;
                div_cnt_reg   <= DC_W'(Q_W);
                div_dvd_reg   <= Q_W'(BUFFER_BYTES);
                div_q_reg     <= '0;
                div_rem_reg   <= 8'd0;
                head_reg      <= '0;
                tail_reg      <= '0;
                fill_reg      <= '0;
                cap_idx_reg   <= 7'd0;
                lb_vld_reg    <= '0;
            end else begin
                if (div_cnt_reg != '0) begin
                    if (div_t >= {1'b0, len_w}) begin
                        div_rem_reg <= div_t - {1'b0, len_w};
                        div_q_reg   <= {div_q_reg[Q_W-2:0], 1'b1};
                    end else begin
                        div_rem_reg <= div_t;
                        div_q_reg   <= {div_q_reg[Q_W-2:0], 1'b0};
                    end
                    div_dvd_reg <= {div_dvd_reg[Q_W-2:0], 1'b0};
                    div_cnt_reg <= div_cnt_reg - DC_W'(1);
                end
                if (cap_take) begin
                    lb_vld_reg[cap_idx_reg[LB_AW-1:0]] <= 1'b1;
                    cap_idx_reg <= st.cap_complete ? 7'd0 : cap_idx_reg + 7'd1;
                end
                if (cmd.cap_drop || cmd.copy_finish) begin
                    lb_vld_reg <= '0;
                end
                if (cmd.copy_finish) begin
                    tail_reg <= tail_next;
                    fill_reg <= fill_reg + Q_W'(1);
                end
                if (cmd.drain_start) begin
                    head_reg <= head_next;
                    fill_reg <= fill_reg - Q_W'(1);
                    fts_reg  <= fts_reg - 8'd1;
                end
            end
            if (cmd.accept) begin
                drop_reg <= 1'b0;
            end else if (cmd.cap_drop) begin
                drop_reg <= 1'b1;
            end
            if (req_take) begin
                if (count_reg < RC_W'(MAX_REQUEST)) begin
                    sum_reg   <= sum_reg + 16'(s_tdata);
                    count_reg <= count_reg + RC_W'(1);
                end else begin
                    count_reg <= RC_W'(MAX_REQUEST + 1);
                end
            end
            if (cmd.req_eval) begin
                count_reg <= '0;
                sum_reg   <= 16'd0;
                if (!discard && ev_rate_we) rate_reg <= {b3_reg, b4_reg};
                if (!discard && ev_fts_we)  fts_reg  <= b3_reg;
            end
        end
    end

endmodule

// ===== src/command_frame_responder_core.sv =====
// Top level of the command frame responder: controller plus datapath.
//
//  Channel   Direction  Payload
//  s_*       in         tuser opcode, tdata in_byte, tlast end_of_frame
//  m_*       out        tuser kind/status/drop, tdata out_byte, tlast last_of_run
//  cfg_*     in         frame_length write, no read-back
//
// One input transaction is taken at a time; s_tready is high only while the
// controller is idle. Each frame or reply byte takes a registered memory
// read, then an output state held while m_tready is low. A completed capture
// frame is copied from the line buffer into the frame FIFO, or dropped if the
// FIFO is full. After reset and after every frame_length write, the depth
// divider runs to completion before input is taken.
module command_frame_responder_core #(
    parameter int BUFFER_BYTES = 1024,
    parameter int MAX_FRAME    = 64,
    parameter int MAX_REQUEST  = 16
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wen,
    input  logic [6:0] cfg_wdata,   // frame_length
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,     // in_byte
    input  logic [1:0] s_tuser,     // opcode
    input  logic       s_tlast,     // end_of_frame
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,     // out_byte
    output logic [4:0] m_tuser,     // item_kind[1:0], status_code[3:2], dropped_frame[4]
    output logic       m_tlast      // last_of_run
);
    import cfr_pkg::*;

    cfr_cmd_t    cmd;
    cfr_status_t st;

    cfr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tready (m_tready),
        .st       (st),
        .cmd      (cmd)
    );

    cfr_datapath #(
        .BUFFER_BYTES (BUFFER_BYTES),
        .MAX_FRAME    (MAX_FRAME),
        .MAX_REQUEST  (MAX_REQUEST)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .cmd       (cmd),
        .st        (st),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    assign s_tready = cmd.in_ready;
    assign m_tvalid = cmd.out_valid;

endmodule

// ===== src/cfr_checker.sv =====
// Port-level checks of the command frame responder, bound to the top level.
module cfr_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic [4:0] m_tuser,
    input logic       m_tlast
);
    import cfr_pkg::*;

    // A held result keeps its payload until the transaction completes.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("result changed while stalled");

    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result offered right after reset");

    a_kind_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tuser[1:0] != 2'd3)
        else $error("illegal result kind");

    a_status_only: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1:0] == KIND_STATUS |-> m_tlast && m_tdata == 8'd0)
        else $error("status-only result carries data");

    // Results and input never overlap: one transaction is worked at a time.
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready)
        else $error("input taken while a result is pending");

endmodule

bind command_frame_responder_core cfr_checker u_cfr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

// ===== tb/tb_command_frame_responder_core.sv =====
// Self-checking testbench of the command frame responder core.
`timescale 1ns / 1ps

module tb_command_frame_responder_core;
    import cfr_pkg::*;

    localparam int BUF_BYTES = 1024;
    localparam int MAX_FRM   = 64;
    localparam int MAX_REQ   = 16;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int HOLD_CYCLES = 300;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic       last;
        logic [1:0] status;
        logic       drop;
    } resp_t;

    typedef struct {
        logic [1:0] op;
        logic [7:0] data;
        logic       eof;
    } byte_in_t;

    logic       aclk;
    logic       aresetn;
    logic       cfg_wen;
    logic [6:0] cfg_wdata;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;
    logic [1:0] s_tuser;
    logic       s_tlast;
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;
    logic [4:0] m_tuser;
    logic       m_tlast;

    command_frame_responder_core #(
        .BUFFER_BYTES(BUF_BYTES), .MAX_FRAME(MAX_FRM), .MAX_REQUEST(MAX_REQ)
    ) dut (
        .aclk(aclk), .aresetn(aresetn), .cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser), .s_tlast(s_tlast), .m_tvalid(m_tvalid),
        .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser), .m_tlast(m_tlast)
    );

    // Shadow state of the responder.
    logic [7:0]  req_bytes [MAX_REQ];
    int          req_cnt;
    logic [15:0] req_sum;
    logic [15:0] rate_reg;
    logic [7:0]  frames_left;
    logic [7:0]  frame_mem [BUF_BYTES];
    int          head_ptr, tail_ptr, fill_cnt, cap_idx;
    logic [7:0]  line_buf [MAX_FRM];
    logic [6:0]  frame_len_reg;

    resp_t expected_q[$];
    int    errors = 0;
    int    cycles = 0;
    int    sent_cnt;
    int    skip_pred;
    int    hold_cnt;
    logic  hold_start;
    logic  hold_off;
    byte_in_t pending_q[$];

    assign hold_off = (hold_cnt != 0);

    function automatic int eff_len();
        int f;
        f = frame_len_reg;
        if (f < 1) f = 1;
        if (f > MAX_FRM) f = MAX_FRM;
        return f;
    endfunction

    function automatic void push_resp(logic [1:0] k, logic [7:0] d, logic l,
                                      logic [1:0] s, logic dr);
        resp_t r;
        r.kind = k; r.data = d; r.last = l; r.status = s; r.drop = dr;
        expected_q.push_back(r);
    endfunction

    function automatic void clear_fifo();
        head_ptr = 0; tail_ptr = 0; fill_cnt = 0; cap_idx = 0;
        foreach (line_buf[i]) line_buf[i] = 8'h00;
    endfunction

    function automatic void predict_drain(logic dr);
        int len, cap, base;
        len = eff_len();
        cap = BUF_BYTES / len;
        if (fill_cnt == 0 || frames_left == 0) begin
            if (dr) push_resp(KIND_STATUS, 8'h00, 1'b1, ST_NONE, 1'b1);
            return;
        end
        base = (head_ptr % cap) * len;
        head_ptr = (head_ptr + 1) % cap;
        fill_cnt--;
        frames_left--;
        for (int i = 0; i < len; i++)
            push_resp(KIND_FRAME, frame_mem[base + i], i + 1 == len, ST_NONE,
                      (i == 0) ? dr : 1'b0);
    endfunction

    function automatic void predict_capture(logic [7:0] b, logic eof);
        int len, cap;
        logic dr;
        len = eff_len();
        cap = BUF_BYTES / len;
        dr = 1'b0;
        if (cap_idx >= len) cap_idx = 0;
        line_buf[cap_idx] = b;
        cap_idx++;
        if (!eof && cap_idx < len) return;
        if (fill_cnt >= cap) begin
            dr = 1'b1;
        end else begin
            for (int i = 0; i < len; i++) frame_mem[(tail_ptr % cap) * len + i] = line_buf[i];
            tail_ptr = (tail_ptr + 1) % cap;
            fill_cnt++;
        end
        cap_idx = 0;
        foreach (line_buf[i]) line_buf[i] = 8'h00;
        predict_drain(dr);
    endfunction

    function automatic void predict_request(logic [7:0] b, logic eof);
        int n, len, depth;
        logic [15:0] chk, rcv, s;
        logic bad, reply, acc;
        logic [1:0] st;
        if (req_cnt < MAX_REQ) begin
            req_bytes[req_cnt] = b;
            req_sum = req_sum + b;
            req_cnt++;
        end else begin
            req_cnt = MAX_REQ + 1;
        end
        if (!eof) return;
        n = req_cnt;
        chk = req_sum;
        req_cnt = 0;
        req_sum = 16'h0;
        if (n > MAX_REQ || n < MIN_REQUEST || frames_left != 0) return;
        chk = chk - req_bytes[n-1] - req_bytes[n-2];
        rcv = {req_bytes[n-1], req_bytes[n-2]};
        bad = (chk != rcv);
        len = n;
        reply = 1'b1;
        acc = 1'b0;
        case (req_bytes[1][6:0])
            CMD_RATE: begin
                acc = 1'b1;
                if (req_bytes[1][RD_BIT]) begin
                    len = LEN_LONG_RD;
                    req_bytes[2] = TAG_RATE;
                    req_bytes[3] = rate_reg[15:8];
                    req_bytes[4] = rate_reg[7:0];
                end else begin
                    len = LEN_RATE_WR;
                    rate_reg = {req_bytes[3], req_bytes[4]};
                    req_bytes[2] = 8'h00;
                end
            end
            CMD_LEN: begin
                acc = 1'b1;
                if (req_bytes[1][RD_BIT]) begin
                    len = LEN_LEN_RD;
                    req_bytes[2] = TAG_LEN;
                    req_bytes[3] = 8'(eff_len());
                end
            end
            CMD_FRAMES: begin
                if (!req_bytes[1][RD_BIT]) begin
                    reply = 1'b0;
                    frames_left = req_bytes[3];
                end
            end
            CMD_DEPTH: begin
                if (req_bytes[1][RD_BIT]) begin
                    len = LEN_LONG_RD;
                    depth = BUF_BYTES / eff_len();
                    req_bytes[3] = 8'(depth >> 8);
                    req_bytes[4] = 8'(depth);
                end
            end
            default: reply = 1'b0;
        endcase
        if (reply) begin
            s = 16'h0;
            for (int i = 0; i + 2 < len; i++) s = s + req_bytes[i];
            req_bytes[len-2] = s[15:8];
            req_bytes[len-1] = s[7:0];
            for (int i = 0; i < len; i++) begin
                st = (i == 0 && bad) ? ST_MISMATCH : (acc ? ST_ACCEPTED : ST_NONE);
                push_resp(KIND_REPLY, req_bytes[i], i + 1 == len, st, 1'b0);
            end
        end else if (bad) begin
            push_resp(KIND_STATUS, 8'h00, 1'b1, ST_MISMATCH, 1'b0);
        end
    endfunction

    function automatic void predict_item(byte_in_t it);
        if (it.op == OP_REQ) predict_request(it.data, it.eof);
        else if (it.op == OP_CAP) predict_capture(it.data, it.eof);
        else if (it.op == OP_TXDONE) predict_drain(1'b0);
    endfunction

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Prediction happens at acceptance so the expectation is queued in order.
    // Results whose values were typed in ahead replace the predicted ones.
    always @(posedge aclk) begin
        int n0;
        if (aresetn && s_tvalid && s_tready) begin
            n0 = expected_q.size();
            predict_item(pending_q.pop_front());
            while (skip_pred > 0 && expected_q.size() > n0) begin
                void'(expected_q.pop_back());
                skip_pred--;
            end
        end
    end

    // Long receiver hold-off, counted here once started by the stimulus.
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_cnt <= 0;
        end else if (hold_start) begin
            hold_cnt <= HOLD_CYCLES;
        end else if (hold_cnt != 0) begin
            hold_cnt <= hold_cnt - 1;
        end
    end

    // Receiver: random stalls plus the long hold-off.
    always @(posedge aclk) begin
        resp_t got, exp;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = {m_tuser[1:0], m_tdata, m_tlast, m_tuser[3:2], m_tuser[4]};
                if (expected_q.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result %h", $time, got);
                end else begin
                    exp = expected_q.pop_front();
                    if (got !== exp) begin
                        errors++;
                        $display("%0t: expected kind %0d byte %h last %b st %0d drop %b, got kind %0d byte %h last %b st %0d drop %b",
                                 $time, exp.kind, exp.data, exp.last, exp.status, exp.drop,
                                 got.kind, got.data, got.last, got.status, got.drop);
                    end
                end
            end
            m_tready <= hold_off ? 1'b0 : (($urandom_range(0, 9) < 7) || (cycles % 512 < 100));
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Sends one transaction, keeping s_tvalid high for a back-to-back item when keep is set.
    task automatic send_item(logic [1:0] op, logic [7:0] b, logic eof, bit keep);
        byte_in_t it;
        it.op = op; it.data = b; it.eof = eof;
        pending_q.push_back(it);
        sent_cnt++;
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= b;
        s_tlast <= eof;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (!keep) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
    endtask

    // Sends a whole request: a random header byte 0, command, payload, then checksum.
    task automatic send_request(logic [7:0] cmd, logic [7:0] p [], bit corrupt);
        logic [15:0] s;
        logic [7:0] hdr;
        hdr = 8'($urandom);
        s = hdr + cmd;
        foreach (p[i]) s = s + p[i];
        if (corrupt) s = s ^ 16'(1 << $urandom_range(0, 15));
        send_item(OP_REQ, hdr, 1'b0, $urandom_range(0, 1));
        send_item(OP_REQ, cmd, 1'b0, $urandom_range(0, 1));
        foreach (p[i]) send_item(OP_REQ, p[i], 1'b0, $urandom_range(0, 1));
        send_item(OP_REQ, s[7:0], 1'b0, $urandom_range(0, 1));
        send_item(OP_REQ, s[15:8], 1'b1, $urandom_range(0, 1));
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (expected_q.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
    endtask

    task automatic write_len(logic [6:0] v);
        wait_drained();
        cfg_wen <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_wen <= 1'b0;
        frame_len_reg = v;
        clear_fifo();
        repeat (20) @(posedge aclk);
    endtask

    task automatic rand_request();
        logic [7:0] p [];
        logic [7:0] cmd;
        int k;
        k = $urandom_range(0, 9);
        cmd = {1'($urandom), 7'(k < 2 ? CMD_RATE : k < 4 ? CMD_LEN : k < 6 ? CMD_DEPTH :
                                 k < 8 ? CMD_FRAMES : $urandom_range(0, 127))};
        if (cmd[6:0] == CMD_FRAMES && !cmd[RD_BIT]) begin
            p = new[2];
            p[0] = 8'($urandom);
            p[1] = 8'($urandom_range(0, 3));
        end else begin
            p = new[$urandom_range(1, 12)];
            foreach (p[i]) p[i] = 8'($urandom);
        end
        send_request(cmd, p, $urandom_range(0, 4) == 0);
    endtask

    // Directed table: op, byte, eof.
    byte_in_t dir_tab [] = '{
        '{OP_REQ, 8'h00, 1'b0}, '{OP_REQ, 8'h81, 1'b0}, '{OP_REQ, 8'h00, 1'b0},
        '{OP_REQ, 8'h81, 1'b0}, '{OP_REQ, 8'h00, 1'b1},
        '{OP_REQ, 8'hFF, 1'b0}, '{OP_REQ, 8'h02, 1'b0}, '{OP_REQ, 8'h00, 1'b0},
        '{OP_REQ, 8'h00, 1'b1},
        '{OP_REQ, 8'hAA, 1'b0}, '{OP_REQ, 8'h55, 1'b1},
        '{OP_TXDONE, 8'h00, 1'b0},
        '{OP_CAP, 8'hFF, 1'b0}, '{OP_CAP, 8'h00, 1'b1},
        '{OP_IGNORE, 8'h5A, 1'b1}
    };

    initial begin
        logic [7:0] p [];
        int phase_end;
        sent_cnt = 0; skip_pred = 0; hold_start = 1'b0;
        aresetn = 1'b0; cfg_wen = 1'b0; cfg_wdata = '0;
        s_tvalid = 1'b0; s_tdata = '0; s_tuser = '0; s_tlast = 1'b0;
        req_cnt = 0; req_sum = '0; rate_reg = '0; frames_left = '0;
        frame_len_reg = FRAME_LEN_RESET;
        foreach (frame_mem[i]) frame_mem[i] = 8'h00;
        foreach (req_bytes[i]) req_bytes[i] = 8'h00;
        clear_fifo();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (20) @(posedge aclk);

        // Reading the rate right after reset answers a zero rate; the command echo, the tag and the sum are nonzero.
        push_resp(KIND_REPLY, 8'h00, 1'b0, ST_ACCEPTED, 1'b0);
        push_resp(KIND_REPLY, 8'h81, 1'b0, ST_ACCEPTED, 1'b0);
        push_resp(KIND_REPLY, TAG_RATE, 1'b0, ST_ACCEPTED, 1'b0);
        push_resp(KIND_REPLY, 8'h00, 1'b0, ST_ACCEPTED, 1'b0);
        push_resp(KIND_REPLY, 8'h00, 1'b0, ST_ACCEPTED, 1'b0);
        push_resp(KIND_REPLY, 8'h00, 1'b0, ST_ACCEPTED, 1'b0);
        push_resp(KIND_REPLY, 8'h83, 1'b1, ST_ACCEPTED, 1'b0);
        skip_pred = 7;
        foreach (dir_tab[i]) begin
            send_item(dir_tab[i].op, dir_tab[i].data, dir_tab[i].eof, 1'b0);
        end
        // Extremes: long request, all-ones rate write, rate and depth reads, odd commands.
        p = new[15]; foreach (p[i]) p[i] = 8'hFF;
        send_request({1'b0, CMD_RATE}, p, 1'b0);
        p = new[2]; p[0] = 8'hFF; p[1] = 8'hFF;
        send_request({1'b0, CMD_RATE}, p, 1'b0);
        send_request({1'b1, CMD_RATE}, p, 1'b1);
        send_request({1'b1, CMD_DEPTH}, p, 1'b0);
        send_request({1'b0, CMD_DEPTH}, p, 1'b0);
        send_request({1'b1, CMD_FRAMES}, p, 1'b0);
        send_request(8'h7F, p, 1'b1);

        // Random phases over several frame lengths, the extremes among them.
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: write_len(7'd1);
                1: write_len(7'd0);
                2: write_len(7'd127);
                3: write_len(7'd64);
                default: write_len(7'($urandom_range(2, 12)));
            endcase
            phase_end = sent_cnt + 8;
            while (sent_cnt < phase_end) begin
                int k;
                k = $urandom_range(0, 9);
                if (frames_left == 0 && k < 4) begin
                    rand_request();
                end else if (k < 8) begin
                    repeat ($urandom_range(1, 6))
                        send_item(OP_CAP, 8'($urandom), $urandom_range(0, 5) == 0,
                                  $urandom_range(0, 2) != 0);
                end else if (k == 8) begin
                    send_item(OP_TXDONE, 8'($urandom), 1'($urandom), 1'b0);
                end else begin
                    send_item(OP_REQ, 8'($urandom), 1'($urandom), 1'b0);
                end
            end
            if (ph == 1) begin
                // The sink holds off while captures keep coming and drains stall the input.
                wait_drained();
                hold_start <= 1'b1;
                @(posedge aclk);
                hold_start <= 1'b0;
                p = new[2]; p[0] = 8'h00; p[1] = 8'd5;
                send_request({1'b0, CMD_FRAMES}, p, 1'b0);
                repeat (12) send_item(OP_CAP, 8'($urandom), 1'b0, 1'b1);
                wait_drained();
            end
        end
        wait_drained();
        if (errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
src/cfr_pkg.sv
src/cfr_ctrl.sv
src/cfr_datapath.sv
src/command_frame_responder_core.sv
src/cfr_checker.sv
tb/tb_command_frame_responder_core.sv
